// ===== hdl/psu_pkg.sv =====
// Shared constants and types for the prime sum block.
package psu_pkg;

	localparam int DEF_VALUE_BITS = 16;
	localparam int SUM_W = 26;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam int FIRST_PRIME = 2;

	// Status of the remainder unit toward the sequencer.
	typedef struct packed {
		logic done;
		logic rem_zero;
	} psu_rem_resp_t;

	// Status of the sequencer toward the top level.
	typedef struct packed {
		logic busy;
		logic fin;
	} psu_stat_t;

endpackage

// ===== hdl/psu_rem.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
module psu_rem
	import psu_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output psu_rem_resp_t         resp
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] shf_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  fits;

	assign trial = {rem_q, shf_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			shf_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// keep the partial remainder, drop the quotient bit
			rem_q <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			shf_q <= {shf_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign resp.done     = done_q;
	assign resp.rem_zero = (rem_q == '0);

endmodule

// ===== hdl/psu_ctrl.sv =====
// Sequencer: walks candidates and trial divisors, accumulates the prime sum.
module psu_ctrl
	import psu_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] limit,
	input  logic                  take,
	output psu_stat_t             stat,
	output logic [SUM_W-1:0]      sum,
	output logic                  rem_start,
	output logic [VALUE_BITS-1:0] rem_dividend,
	output logic [VALUE_BITS-1:0] rem_divisor,
	input  psu_rem_resp_t         rem_resp
);

	localparam int SW = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TEST = 3'd1;
	localparam logic [2:0] ST_DIVW = 3'd2;
	localparam logic [2:0] ST_NEXT = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] lim_q;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS:0]   sq_q;
	logic [SW-1:0]         sum_q;
	logic [SW-1:0]         sum_add;
	logic [VALUE_BITS:0]   sq_next;
	logic                  too_small;

	assign sum_add   = sum_q + SW'(cand_q);
	assign sq_next   = sq_q + {div_q, 1'b1};
	assign too_small = limit[VALUE_BITS-1] || (limit < VALUE_BITS'(FIRST_PRIME));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= too_small ? ST_FIN : ST_TEST;
					end
				end
				ST_TEST: begin
					if (sq_q > {1'b0, cand_q}) begin
						state_q <= (sum_add > SW'(SUM_MAX)) ? ST_FIN : ST_NEXT;
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (rem_resp.done) begin
						state_q <= rem_resp.rem_zero ? ST_NEXT : ST_TEST;
					end
				end
				ST_NEXT: begin
					state_q <= (cand_q == lim_q) ? ST_FIN : ST_TEST;
				end
				ST_FIN: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lim_q  <= limit;
				cand_q <= VALUE_BITS'(FIRST_PRIME);
				div_q  <= VALUE_BITS'(FIRST_PRIME);
				sq_q   <= (VALUE_BITS+1)'(FIRST_PRIME * FIRST_PRIME);
				sum_q  <= '0;
			end
			ST_TEST: begin
				// no divisor up to the square root: candidate is prime
				if (sq_q > {1'b0, cand_q}) begin
					sum_q <= (sum_add > SW'(SUM_MAX)) ? SW'(SUM_MAX) : sum_add;
				end
			end
			ST_DIVW: begin
				if (rem_resp.done && !rem_resp.rem_zero) begin
					div_q <= div_q + 1'b1;
					sq_q  <= sq_next;
				end
			end
			ST_NEXT: begin
				cand_q <= cand_q + 1'b1;
				div_q  <= VALUE_BITS'(FIRST_PRIME);
				sq_q   <= (VALUE_BITS+1)'(FIRST_PRIME * FIRST_PRIME);
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	assign rem_start    = (state_q == ST_TEST) && !(sq_q > {1'b0, cand_q});
	assign rem_dividend = cand_q;
	assign rem_divisor  = div_q;
	assign stat.busy    = (state_q != ST_IDLE);
	assign stat.fin     = (state_q == ST_FIN);
	assign sum          = sum_q[SUM_W-1:0];

endmodule

// ===== hdl/prime_sum_up_to_limit.sv =====
// Top level of the prime sum block: handshakes, output register, sequencer and remainder unit.
// Takes one signed limit word and returns the sum of all primes from 2 up to the limit (0 for
// a limit below 2). Each candidate is tested by trial division with divisors from 2 while the
// divisor squared does not exceed it; every trial runs on one shared remainder unit.
// limit_stall is high while a word is being worked on; the result sits in an output register,
// so the next limit word is taken while the previous sum still waits on sum_stall.
module prime_sum_up_to_limit
	import psu_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         limit_valid,
	output logic                         limit_stall,
	input  logic signed [VALUE_BITS-1:0] limit_value,
	output logic                         sum_valid,
	input  logic                         sum_stall,
	output logic [SUM_W-1:0]             prime_sum
);

	psu_stat_t             stat;
	psu_rem_resp_t         rem_resp;
	logic                  rem_start;
	logic [VALUE_BITS-1:0] rem_dividend;
	logic [VALUE_BITS-1:0] rem_divisor;
	logic [SUM_W-1:0]      sum;
	logic                  take;
	logic                  out_valid_q;
	logic [SUM_W-1:0]      prime_sum_q;

	// output register is free when empty or being drained this cycle
	assign take = stat.fin && (!out_valid_q || !sum_stall);

	psu_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (limit_valid && !stat.busy),
		.limit       (limit_value),
		.take        (take),
		.stat        (stat),
		.sum         (sum),
		.rem_start   (rem_start),
		.rem_dividend(rem_dividend),
		.rem_divisor (rem_divisor),
		.rem_resp    (rem_resp)
	);

	psu_rem #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(rem_dividend),
		.divisor (rem_divisor),
		.resp    (rem_resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!sum_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prime_sum_q <= sum;
		end
	end

	assign limit_stall = stat.busy;
	assign sum_valid   = out_valid_q;
	assign prime_sum   = prime_sum_q;

endmodule

// ===== hdl/psu_chk.sv =====
// Port-level checker for the prime sum block, bound to the top level.
module psu_chk
	import psu_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         limit_valid,
	input logic                         limit_stall,
	input logic signed [VALUE_BITS-1:0] limit_value,
	input logic                         sum_valid,
	input logic                         sum_stall,
	input logic [SUM_W-1:0]             prime_sum
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(prime_sum))
		else $error("result word changed while stalled");

	// a taken limit word makes the block busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		limit_valid && !limit_stall |=> limit_stall)
		else $error("block not busy after taking a limit word");

	// finishing an item always leaves a result word on the output
	a_result_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(limit_stall) |-> sum_valid)
		else $error("item finished without a result word");

	// no sum of primes equals one
	a_sum_not_one: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> prime_sum != SUM_W'(1))
		else $error("impossible prime sum");

endmodule

bind prime_sum_up_to_limit psu_chk #(.VALUE_BITS(VALUE_BITS)) u_psu_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for prime_sum_up_to_limit: directed table, random limits, flow control.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import psu_pkg::*;

	localparam int LIM_W = DEF_VALUE_BITS;
	localparam int RANDOM_WORDS = 72;
	localparam int HOLD_CYCLES = 400;
	localparam int BURST_WORDS = 8;
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int N_ROWS = 25;

	typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

	typedef struct packed {
		logic signed [LIM_W-1:0] lim;
		logic                    typed;
		logic [SUM_W-1:0]        sum;
	} limit_row_t;

	typedef struct {
		logic signed [LIM_W-1:0] lim;
		logic [SUM_W-1:0]        sum;
	} pending_sum_t;

	logic                    clk;
	logic                    arst_n;
	logic                    limit_valid;
	logic                    limit_stall;
	logic signed [LIM_W-1:0] limit_value;
	logic                    sum_valid;
	logic                    sum_stall;
	logic [SUM_W-1:0]        prime_sum;

	pending_sum_t pending_sums[$];
	limit_row_t   limit_rows [0:N_ROWS-1];
	flow_t        flow;
	int           mismatches;
	int           sums_seen;
	int           words_sent;
	int           cycles;
	bit           hold_req;
	bit           hold_seen;

	prime_sum_up_to_limit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_valid (limit_valid),
		.limit_stall (limit_stall),
		.limit_value (limit_value),
		.sum_valid   (sum_valid),
		.sum_stall   (sum_stall),
		.prime_sum   (prime_sum)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sum of primes up to lim by trial division, saturating at the sum width.
	function automatic logic [SUM_W-1:0] prime_total(logic signed [LIM_W-1:0] lim);
		longint unsigned acc;
		int              c;
		int              d;
		bit              composite;
		acc = 0;
		if (lim >= 2) begin
			for (c = 2; c <= int'(lim); c++) begin
				composite = 1'b0;
				for (d = 2; d * d <= c; d++) begin
					if (c % d == 0) begin
						composite = 1'b1;
						break;
					end
				end
				if (!composite) begin
					acc += c;
					if (acc > SUM_MAX) begin
						acc = SUM_MAX;
						break;
					end
				end
			end
		end
		return acc[SUM_W-1:0];
	endfunction

	function automatic int src_idle_pct(flow_t f);
		case (f)
			FLOW_SRC_IDLE: return 47;
			FLOW_BOTH:     return 7;
			default:       return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct(flow_t f);
		case (f)
			FLOW_SINK_STALL: return 47;
			FLOW_BOTH:       return 7;
			default:         return 0;
		endcase
	endfunction

	// Mostly small limits keep the trial division short; a few negatives and mid-size ones.
	function automatic logic signed [LIM_W-1:0] random_limit();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return {1'b1, (LIM_W-1)'($urandom)};
		else if (pick < 20)
			return LIM_W'($urandom_range(0, 3));
		else if (pick < 85)
			return LIM_W'($urandom_range(4, 80));
		else
			return LIM_W'($urandom_range(81, 400));
	endfunction

	// Offer one limit word; valid stays high after acceptance until the next call decides.
	task automatic send_limit(input logic signed [LIM_W-1:0] lim, input bit typed,
			input logic [SUM_W-1:0] typed_sum);
		pending_sum_t entry;
		if ($urandom_range(0, 99) < src_idle_pct(flow)) begin
			limit_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct(flow))
				@(posedge clk);
		end
		limit_valid <= 1'b1;
		limit_value <= lim;
		@(posedge clk);
		while (limit_stall)
			@(posedge clk);
		entry.lim = lim;
		entry.sum = typed ? typed_sum : prime_total(lim);
		pending_sums.push_back(entry);
		words_sent++;
	endtask

	task automatic drain_sums();
		limit_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	// Sink side: check accepted words against the oldest expectation, then pick the next stall.
	initial begin
		int  hold_left;
		bit  stall_next;
		pending_sum_t want;
		hold_left = 0;
		sum_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && sum_valid && !sum_stall) begin
				sums_seen++;
				if (pending_sums.size() == 0) begin
					$error("prime_sum arrived with nothing expected: actual %0d", prime_sum);
					mismatches++;
				end else begin
					want = pending_sums.pop_front();
					if (prime_sum !== want.sum) begin
						$error("prime_sum mismatch for limit %0d: expected %0d, actual %0d",
							want.lim, want.sum, prime_sum);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = $urandom_range(0, 99) < sink_stall_pct(flow);
			end
			sum_stall <= stall_next;
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d sums still pending", cycles,
					pending_sums.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int p;
		mismatches = 0;
		sums_seen = 0;
		words_sent = 0;
		hold_req = 1'b0;
		hold_seen = 1'b0;
		flow = FLOW_FREE;
		arst_n <= 1'b0;
		limit_valid <= 1'b0;
		limit_value <= '0;

		// lim, typed, sum: typed rows are the trivial ones, the rest go through prime_total
		limit_rows = '{
			'{-16'sd32768, 1'b1, 26'd0},
			'{-16'sd32767, 1'b1, 26'd0},
			'{-16'sd16384, 1'b1, 26'd0},
			'{-16'sd2,     1'b1, 26'd0},
			'{-16'sd1,     1'b1, 26'd0},
			'{16'sd0,      1'b1, 26'd0},
			'{16'sd1,      1'b1, 26'd0},
			'{16'sd2,      1'b1, 26'd2},
			'{16'sd3,      1'b1, 26'd5},
			'{16'sd4,      1'b0, 26'd0},
			'{16'sd5,      1'b0, 26'd0},
			'{16'sd7,      1'b0, 26'd0},
			'{16'sd8,      1'b0, 26'd0},
			'{16'sd9,      1'b0, 26'd0},
			'{16'sd10,     1'b0, 26'd0},
			'{16'sd11,     1'b0, 26'd0},
			'{16'sd12,     1'b0, 26'd0},
			'{16'sd25,     1'b0, 26'd0},
			'{16'sd49,     1'b0, 26'd0},
			'{16'sd97,     1'b0, 26'd0},
			'{16'sd121,    1'b0, 26'd0},
			'{16'sd255,    1'b0, 26'd0},
			'{16'sd256,    1'b0, 26'd0},
			'{16'sd1023,   1'b0, 26'd0},
			'{16'sd1024,   1'b0, 26'd0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++)
			send_limit(limit_rows[i].lim, limit_rows[i].typed, limit_rows[i].sum);

		// Four flow-control phases; hold the sender at each boundary until all sums are back.
		for (p = 0; p < 4; p++) begin
			drain_sums();
			flow = flow_t'(p);
			for (i = 0; i < RANDOM_WORDS / 4; i++) begin
				if (flow == FLOW_SINK_STALL && i == 10) begin
					// Long sink hold-off while cheap words keep coming, so the block backs up.
					hold_req = 1'b1;
					repeat (BURST_WORDS)
						send_limit($urandom_range(0, 1) ? {1'b1, (LIM_W-1)'($urandom)} :
							LIM_W'($urandom_range(0, 5)), 1'b0, '0);
				end
				send_limit(random_limit(), 1'b0, '0);
			end
		end

		limit_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d limit words (%0d directed), checked %0d sums in four flow phases",
			words_sent, N_ROWS, sums_seen);
		$display("sink hold-off of %0d cycles %0s, run took %0d cycles", HOLD_CYCLES,
			hold_seen ? "done" : "missed", cycles);
		if (mismatches == 0 && hold_seen)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
